### rtl/fltc_pkg.sv
// Shared types, codes and defaults for the flow/route classifier.
// No dependencies.
package fltc_pkg;

  localparam int FLOW_ENTRIES_DEF  = 64;
  localparam int ROUTE_ENTRIES_DEF = 64;

  localparam logic [1:0] OP_LOOKUP    = 2'd0;
  localparam logic [1:0] OP_ADD_FLOW  = 2'd1;
  localparam logic [1:0] OP_ADD_ROUTE = 2'd2;
  localparam logic [1:0] OP_CLEAR     = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FLOW_HIT  = 3'd1;
  localparam logic [2:0] ST_ROUTE_HIT = 3'd2;
  localparam logic [2:0] ST_MISS      = 3'd3;
  localparam logic [2:0] ST_INVALID   = 3'd4;
  localparam logic [2:0] ST_DUP       = 3'd5;
  localparam logic [2:0] ST_NOSPACE   = 3'd6;

  localparam logic [1:0] AT_DROP    = 2'd0;
  localparam logic [1:0] AT_FORWARD = 2'd1;
  localparam logic [1:0] AT_REWRITE = 2'd2;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [5:0] MAX_DEPTH = 6'd32;

  // flow entry: key plus packed action
  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] l4_sport;
    logic [15:0] l4_dport;
    logic [7:0]  proto;
    logic [1:0]  act_type;
    logic [3:0]  act_mask;
  } flow_ent_t;

  typedef struct packed {
    logic [31:0] prefix;
    logic [5:0]  len;
    logic [1:0]  act_type;
    logic [3:0]  act_mask;
  } route_ent_t;

  typedef struct packed {
    logic flow_eq;
    logic route_hit;
    logic route_dup;
  } cmp_t;

  function automatic logic [31:0] prefix_mask(input logic [5:0] depth);
    prefix_mask = ~(32'hFFFF_FFFF >> depth);
  endfunction

endpackage

### rtl/fltc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fltc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/fltc_cmp.sv
// Shared compare unit: one flow entry and one route entry against the key.
// Depends on fltc_pkg.
module fltc_cmp (
  input  fltc_pkg::flow_ent_t  flow_ent,
  input  fltc_pkg::route_ent_t route_ent,
  input  fltc_pkg::flow_ent_t  key,
  input  logic [5:0]           depth,
  input  logic [5:0]           best,
  output fltc_pkg::cmp_t       res
);

  logic len_ok;

  always_comb begin
    len_ok = (route_ent.len != 6'd0) && (route_ent.len <= fltc_pkg::MAX_DEPTH);
    res.flow_eq = (flow_ent.src_ip == key.src_ip) && (flow_ent.dst_ip == key.dst_ip) &&
                  (flow_ent.l4_sport == key.l4_sport) &&
                  (flow_ent.l4_dport == key.l4_dport) && (flow_ent.proto == key.proto);
    res.route_hit = len_ok && (route_ent.len > best) &&
                    ((key.dst_ip & fltc_pkg::prefix_mask(route_ent.len)) == route_ent.prefix);
    res.route_dup = (route_ent.prefix == key.dst_ip) && (route_ent.len == depth);
  end

endmodule

### rtl/flow_exact_then_lpm_classifier.sv
// Flow/route classifier top: exact 5-tuple match, longest-prefix fallback.
// Invalid, no-space and clear answers come straight from accept; a flow insert or flow hit
// scans the loaded flows, a route insert scans the loaded routes, and a lookup that falls
// to routes scans the loaded flows and then the loaded routes.
// Throughput: one beat at a time; busy drops as a scan's result strobe rises, and immediate answers never raise busy.
// Reset: synchronous active-low clears counts and sequencer; tables are not cleared.
module flow_exact_then_lpm_classifier #(
  parameter int FLOW_ENTRIES  = fltc_pkg::FLOW_ENTRIES_DEF,
  parameter int ROUTE_ENTRIES = fltc_pkg::ROUTE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_src_ip,
  input  logic [31:0] in_dst_ip,
  input  logic [15:0] in_l4_sport,
  input  logic [15:0] in_l4_dport,
  input  logic [7:0]  in_proto,
  input  logic [5:0]  in_prefix_depth,
  input  logic [1:0]  in_act_type,
  input  logic [7:0]  in_rewrite_mask,
  input  logic        in_reserved_nonzero,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [1:0]  out_hit_type,
  output logic [3:0]  out_hit_mask,
  output logic [7:0]  out_rule_slot
);

  localparam int FAW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int RAW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int FCW = $clog2(FLOW_ENTRIES + 1);
  localparam int RCW = $clog2(ROUTE_ENTRIES + 1);
  localparam int FW  = $bits(fltc_pkg::flow_ent_t);
  localparam int RW  = $bits(fltc_pkg::route_ent_t);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FSCAN = 2'd1;
  localparam logic [1:0] S_RSCAN = 2'd2;

  logic [1:0] state_r;
  logic [FCW-1:0] flows_r, fcnt_r;
  logic [RCW-1:0] routes_r, rcnt_r;
  logic pend_r;
  logic [FAW-1:0] fpend_r;
  logic [RAW-1:0] rpend_r;
  logic [1:0] op_r;
  logic [5:0] depth_r;
  fltc_pkg::flow_ent_t key_r;
  logic hit_r;
  logic [5:0] best_r;
  logic [1:0] htype_r;
  logic [3:0] hmask_r;
  logic [7:0] hidx_r;

  fltc_pkg::flow_ent_t  flow_rd, flow_wd;
  fltc_pkg::route_ent_t route_rd, route_wd;
  fltc_pkg::cmp_t       cmp;
  logic flow_we, route_we;
  logic act_ok, flow_ok, route_ok;
  logic fdone, rdone;
  logic [7:0] ridx_sum;
  logic valid_nxt;

  assign busy = (state_r != S_IDLE);

  // action/key validity checks straight from the ports; only used at accept
  always_comb begin
    act_ok = !in_reserved_nonzero &&
             (((in_act_type == fltc_pkg::AT_DROP || in_act_type == fltc_pkg::AT_FORWARD) &&
               in_rewrite_mask == 8'd0) ||
              (in_act_type == fltc_pkg::AT_REWRITE && in_rewrite_mask != 8'd0 &&
               in_rewrite_mask[7:4] == 4'd0));
    flow_ok  = act_ok && (in_proto == fltc_pkg::PROTO_TCP || in_proto == fltc_pkg::PROTO_UDP);
    route_ok = act_ok && (in_prefix_depth != 6'd0) &&
               (in_prefix_depth <= fltc_pkg::MAX_DEPTH) &&
               ((in_dst_ip & fltc_pkg::prefix_mask(in_prefix_depth)) == in_dst_ip);
  end

  always_comb begin
    flow_wd  = key_r;
    route_wd = '{prefix: key_r.dst_ip, len: depth_r,
                 act_type: key_r.act_type, act_mask: key_r.act_mask};
  end

  // scan finished once every loaded entry is issued and the last compare is in
  assign fdone = (fcnt_r == flows_r) && !pend_r;
  assign rdone = (rcnt_r == routes_r) && !pend_r;
  assign flow_we  = (state_r == S_FSCAN) && fdone && (op_r == fltc_pkg::OP_ADD_FLOW) &&
                    !hit_r;
  assign route_we = (state_r == S_RSCAN) && rdone && (op_r == fltc_pkg::OP_ADD_ROUTE) &&
                    !hit_r;

  // result strobe: immediate answers at accept, else at the end of the last scan
  always_comb begin
    unique case (state_r)
      S_IDLE: begin
        valid_nxt = start &&
                    ((in_action == fltc_pkg::OP_CLEAR) ||
                     (in_action == fltc_pkg::OP_ADD_FLOW &&
                      ((flows_r >= FCW'(FLOW_ENTRIES)) || !flow_ok)) ||
                     (in_action == fltc_pkg::OP_ADD_ROUTE &&
                      ((routes_r >= RCW'(ROUTE_ENTRIES)) || !route_ok)));
      end
      S_FSCAN: valid_nxt = fdone && ((op_r != fltc_pkg::OP_LOOKUP) || hit_r);
      S_RSCAN: valid_nxt = rdone;
      default: valid_nxt = 1'b0;
    endcase
  end

  fltc_ram #(.WIDTH(FW), .DEPTH(FLOW_ENTRIES)) u_flow_ram (
    .clk(clk), .we(flow_we), .waddr(flows_r[FAW-1:0]), .wdata(flow_wd),
    .raddr(fcnt_r[FAW-1:0]), .rdata(flow_rd)
  );

  fltc_ram #(.WIDTH(RW), .DEPTH(ROUTE_ENTRIES)) u_route_ram (
    .clk(clk), .we(route_we), .waddr(routes_r[RAW-1:0]), .wdata(route_wd),
    .raddr(rcnt_r[RAW-1:0]), .rdata(route_rd)
  );

  fltc_cmp u_cmp (
    .flow_ent(flow_rd), .route_ent(route_rd), .key(key_r),
    .depth(depth_r), .best(best_r), .res(cmp)
  );

  // combined store index: flows first, then routes
  assign ridx_sum = 8'(flows_r) + 8'(rpend_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      flows_r   <= '0;
      routes_r  <= '0;
      pend_r    <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r    <= in_action;
            depth_r <= in_prefix_depth;
            key_r   <= '{src_ip: in_src_ip, dst_ip: in_dst_ip, l4_sport: in_l4_sport,
                         l4_dport: in_l4_dport, proto: in_proto,
                         act_type: in_act_type, act_mask: in_rewrite_mask[3:0]};
            fcnt_r  <= '0;
            rcnt_r  <= '0;
            pend_r  <= 1'b0;
            hit_r   <= 1'b0;
            best_r  <= 6'd0;
            htype_r <= 2'd0;
            hmask_r <= 4'd0;
            hidx_r  <= 8'd0;
            out_hit_type  <= 2'd0;
            out_hit_mask  <= 4'd0;
            out_rule_slot <= 8'd0;
            unique case (in_action)
              fltc_pkg::OP_LOOKUP: state_r <= S_FSCAN;
              fltc_pkg::OP_ADD_FLOW: begin
                if (flows_r >= FCW'(FLOW_ENTRIES)) begin
                  out_status <= fltc_pkg::ST_NOSPACE;
                end else if (!flow_ok) begin
                  out_status <= fltc_pkg::ST_INVALID;
                end else begin
                  state_r <= S_FSCAN;
                end
              end
              fltc_pkg::OP_ADD_ROUTE: begin
                if (routes_r >= RCW'(ROUTE_ENTRIES)) begin
                  out_status <= fltc_pkg::ST_NOSPACE;
                end else if (!route_ok) begin
                  out_status <= fltc_pkg::ST_INVALID;
                end else begin
                  state_r <= S_RSCAN;
                end
              end
              default: begin
                flows_r    <= '0;
                routes_r   <= '0;
                out_status <= fltc_pkg::ST_OK;
              end
            endcase
          end
        end
        S_FSCAN: begin
          // first matching flow wins
          if (pend_r && cmp.flow_eq && !hit_r) begin
            hit_r   <= 1'b1;
            htype_r <= flow_rd.act_type;
            hmask_r <= flow_rd.act_mask;
            hidx_r  <= 8'(fpend_r);
          end
          if (fcnt_r != flows_r) begin
            pend_r  <= 1'b1;
            fpend_r <= fcnt_r[FAW-1:0];
            fcnt_r  <= fcnt_r + 1'b1;
          end else begin
            pend_r <= 1'b0;
          end
          if (fdone) begin
            if (op_r == fltc_pkg::OP_LOOKUP) begin
              if (hit_r) begin
                out_status    <= fltc_pkg::ST_FLOW_HIT;
                out_hit_type  <= htype_r;
                out_hit_mask  <= hmask_r;
                out_rule_slot <= hidx_r;
                state_r       <= S_IDLE;
              end else begin
                state_r <= S_RSCAN;
              end
            end else begin
              out_status <= hit_r ? fltc_pkg::ST_DUP : fltc_pkg::ST_OK;
              state_r    <= S_IDLE;
              if (!hit_r) begin
                flows_r <= flows_r + 1'b1;
              end
            end
          end
        end
        S_RSCAN: begin
          if (pend_r) begin
            if (op_r == fltc_pkg::OP_LOOKUP) begin
              if (cmp.route_hit) begin
                hit_r   <= 1'b1;
                best_r  <= route_rd.len;
                htype_r <= route_rd.act_type;
                hmask_r <= route_rd.act_mask;
                hidx_r  <= ridx_sum;
              end
            end else if (cmp.route_dup) begin
              hit_r <= 1'b1;
            end
          end
          if (rcnt_r != routes_r) begin
            pend_r  <= 1'b1;
            rpend_r <= rcnt_r[RAW-1:0];
            rcnt_r  <= rcnt_r + 1'b1;
          end else begin
            pend_r <= 1'b0;
          end
          if (rdone) begin
            state_r   <= S_IDLE;
            if (op_r == fltc_pkg::OP_LOOKUP) begin
              out_status    <= hit_r ? fltc_pkg::ST_ROUTE_HIT : fltc_pkg::ST_MISS;
              out_hit_type  <= htype_r;
              out_hit_mask  <= hmask_r;
              out_rule_slot <= hidx_r;
            end else begin
              out_status <= hit_r ? fltc_pkg::ST_DUP : fltc_pkg::ST_OK;
              if (!hit_r) begin
                routes_r <= routes_r + 1'b1;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### tb/tb_flow_exact_then_lpm_classifier.sv
// Self-checking bench for the flow/route classifier: exact five-tuple match
// with longest-prefix fallback. Depends on fltc_pkg and the classifier RTL.
module tb_flow_exact_then_lpm_classifier;
  timeunit 1ns;
  timeprecision 1ps;
  import fltc_pkg::*;

  localparam int NFLOW  = 64;
  localparam int NROUTE = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  // one command beat
  typedef struct {
    logic [1:0]  op;
    logic [31:0] sip;
    logic [31:0] dip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  proto;
    logic [5:0]  depth;
    logic [1:0]  atype;
    logic [7:0]  amask;
    logic        resv;
    logic        hold;   // wait for drain before sending
  } cmd_t;

  typedef struct {
    logic [2:0] status;
    logic [1:0] htype;
    logic [3:0] hmask;
    logic [7:0] idx;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0]  in_action = '0;
  logic [31:0] in_src_ip = '0;
  logic [31:0] in_dst_ip = '0;
  logic [15:0] in_l4_sport = '0;
  logic [15:0] in_l4_dport = '0;
  logic [7:0]  in_proto = '0;
  logic [5:0]  in_prefix_depth = '0;
  logic [1:0]  in_act_type = '0;
  logic [7:0]  in_rewrite_mask = '0;
  logic        in_reserved_nonzero = 1'b0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [1:0]  out_hit_type;
  logic [3:0]  out_hit_mask;
  logic [7:0]  out_rule_slot;

  always #10 clk = ~clk;

  flow_exact_then_lpm_classifier i_dut (.*);

  // shadow copy of the rule tables
  flow_ent_t  flow_tbl [NFLOW];
  route_ent_t route_tbl[NROUTE];
  int flow_cnt, route_cnt;

  cmd_t     pending_cmds[$];
  verdict_t expected_verdicts[$];
  int  errors = 0;
  bit  stim_done = 0;
  bit  gap_free = 0;     // long stretch without sender idling
  bit  took = 0;         // beat accepted at the last rising edge
  int  quiet_cycles = 0;
  int  sent = 0;

  function automatic bit action_ok(logic [1:0] t, logic [7:0] m, logic r);
    if (r) return 0;
    if (t == AT_DROP || t == AT_FORWARD) return m == 0;
    if (t == AT_REWRITE) return m != 0 && m[7:4] == 0;
    return 0;
  endfunction

  function automatic logic [31:0] depth_mask(logic [5:0] d);
    return (d == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - d));
  endfunction

  // Computes the classifier verdict and updates the shadow tables.
  function automatic verdict_t classify(cmd_t c);
    verdict_t v;
    int best;
    logic [31:0] m;
    v = '{ST_OK, 2'd0, 4'd0, 8'd0};
    case (c.op)
      OP_LOOKUP: begin
        v.status = ST_MISS;
        for (int i = 0; i < flow_cnt; i++) begin
          if (flow_tbl[i].src_ip == c.sip && flow_tbl[i].dst_ip == c.dip &&
              flow_tbl[i].l4_sport == c.sport && flow_tbl[i].l4_dport == c.dport &&
              flow_tbl[i].proto == c.proto) begin
            v = '{ST_FLOW_HIT, flow_tbl[i].act_type, flow_tbl[i].act_mask, 8'(i)};
            return v;
          end
        end
        best = 0;
        for (int i = 0; i < route_cnt; i++) begin
          m = depth_mask(route_tbl[i].len);
          if ((c.dip & m) == route_tbl[i].prefix && route_tbl[i].len > best) begin
            best = route_tbl[i].len;
            // routes sit after all flows in the combined action store
            v = '{ST_ROUTE_HIT, route_tbl[i].act_type, route_tbl[i].act_mask,
                  8'(flow_cnt + i)};
          end
        end
      end
      OP_ADD_FLOW: begin
        if (flow_cnt >= NFLOW) v.status = ST_NOSPACE;
        else if ((c.proto != PROTO_TCP && c.proto != PROTO_UDP) ||
                 !action_ok(c.atype, c.amask, c.resv)) v.status = ST_INVALID;
        else begin
          for (int i = 0; i < flow_cnt; i++)
            if (flow_tbl[i].src_ip == c.sip && flow_tbl[i].dst_ip == c.dip &&
                flow_tbl[i].l4_sport == c.sport && flow_tbl[i].l4_dport == c.dport &&
                flow_tbl[i].proto == c.proto) v.status = ST_DUP;
          if (v.status == ST_OK) begin
            flow_tbl[flow_cnt] = '{c.sip, c.dip, c.sport, c.dport, c.proto,
                                   c.atype, c.amask[3:0]};
            flow_cnt++;
          end
        end
      end
      OP_ADD_ROUTE: begin
        if (route_cnt >= NROUTE) v.status = ST_NOSPACE;
        else if (c.depth < 1 || c.depth > MAX_DEPTH ||
                 (c.dip & depth_mask(c.depth)) != c.dip ||
                 !action_ok(c.atype, c.amask, c.resv)) v.status = ST_INVALID;
        else begin
          for (int i = 0; i < route_cnt; i++)
            if (route_tbl[i].prefix == c.dip && route_tbl[i].len == c.depth)
              v.status = ST_DUP;
          if (v.status == ST_OK) begin
            route_tbl[route_cnt] = '{c.dip, c.depth, c.atype, c.amask[3:0]};
            route_cnt++;
          end
        end
      end
      default: begin
        flow_cnt = 0;
        route_cnt = 0;
      end
    endcase
    return v;
  endfunction

  // Stimulus helpers: pools keep lookups hitting stored rules.
  logic [31:0] sip_pool[$], dip_pool[$];
  logic [15:0] port_pool[$];

  function automatic cmd_t blank_cmd(logic [1:0] op);
    cmd_t c;
    c = '{op, $urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom),
          6'($urandom), 2'($urandom), 8'($urandom), 1'($urandom), 1'b0};
    return c;
  endfunction

  function automatic cmd_t good_action(cmd_t c);
    c.resv = 0;
    c.atype = 2'($urandom_range(0, 2));
    c.amask = (c.atype == AT_REWRITE) ? 8'($urandom_range(1, 15)) : 8'd0;
    return c;
  endfunction

  function automatic cmd_t pool_tuple(cmd_t c);
    c.sip = sip_pool[$urandom_range(0, sip_pool.size() - 1)];
    c.dip = dip_pool[$urandom_range(0, dip_pool.size() - 1)];
    c.sport = port_pool[$urandom_range(0, port_pool.size() - 1)];
    c.dport = port_pool[$urandom_range(0, port_pool.size() - 1)];
    c.proto = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
    return c;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      c = blank_cmd(OP_LOOKUP);
      if ($urandom_range(0, 3) != 0) c = pool_tuple(c);
    end else if (r < 70) begin
      c = blank_cmd(OP_ADD_FLOW);
      if ($urandom_range(0, 4) != 0) c = good_action(pool_tuple(c));
    end else if (r < 97) begin
      c = blank_cmd(OP_ADD_ROUTE);
      if ($urandom_range(0, 4) != 0) begin
        c = good_action(c);
        c.depth = 6'($urandom_range(1, 32));
        c.dip = dip_pool[$urandom_range(0, dip_pool.size() - 1)] & depth_mask(c.depth);
      end
    end else begin
      c = blank_cmd(OP_CLEAR);
    end
    return c;
  endfunction

  initial begin
    cmd_t c;
    for (int i = 0; i < 6; i++) begin
      sip_pool.push_back($urandom);
      dip_pool.push_back($urandom);
      port_pool.push_back(16'($urandom));
    end
    sip_pool.push_back(32'hFFFF_FFFF); dip_pool.push_back(32'h0);
    port_pool.push_back(16'hFFFF); port_pool.push_back(16'h0);

    // directed: empty lookup, each rejection reason, dup, hits, extremes
    c = blank_cmd(OP_LOOKUP); pending_cmds.push_back(c);
    c = good_action(pool_tuple(blank_cmd(OP_ADD_FLOW)));
    c.sip = '1; c.dip = '1; c.sport = '1; c.dport = '1; c.proto = PROTO_UDP;
    c.atype = AT_REWRITE; c.amask = 8'h0F;
    pending_cmds.push_back(c);
    pending_cmds.push_back(c);                        // duplicate flow
    c.op = OP_LOOKUP; pending_cmds.push_back(c);      // flow hit
    c.op = OP_ADD_FLOW; c.sport = 0; c.proto = 8'd1;
    pending_cmds.push_back(c);                        // bad protocol
    c.proto = PROTO_TCP; c.resv = 1; pending_cmds.push_back(c);
    c.resv = 0; c.atype = AT_DROP; c.amask = 8'h01; pending_cmds.push_back(c);
    c.atype = AT_REWRITE; c.amask = 8'h00; pending_cmds.push_back(c);
    c.amask = 8'hF1; pending_cmds.push_back(c);       // mask above bit 3
    c.atype = 2'd3; c.amask = 8'h01; pending_cmds.push_back(c);
    c = good_action(blank_cmd(OP_ADD_ROUTE));
    c.dip = 32'h0A00_0000; c.depth = 6'd8; pending_cmds.push_back(c);
    c.dip = 32'h0A01_0000; c.depth = 6'd16; c.atype = AT_REWRITE; c.amask = 8'h3;
    pending_cmds.push_back(c);
    pending_cmds.push_back(c);                        // duplicate route
    c.depth = 6'd0; pending_cmds.push_back(c);
    c.depth = 6'd33; pending_cmds.push_back(c);
    c.depth = 6'd63; pending_cmds.push_back(c);
    c.depth = 6'd8; pending_cmds.push_back(c);        // unaligned prefix
    c.dip = 32'hFFFF_FFFF; c.depth = 6'd32; c.atype = AT_FORWARD; c.amask = 0;
    pending_cmds.push_back(c);
    c.dip = 32'h8000_0000; c.depth = 6'd1; c.resv = 1; pending_cmds.push_back(c);
    c.resv = 0; pending_cmds.push_back(c);
    c = blank_cmd(OP_LOOKUP); c.proto = 8'd6;
    c.dip = 32'h0A01_0203; pending_cmds.push_back(c); // longest of two
    c.dip = 32'h0A02_0000; pending_cmds.push_back(c);
    c.dip = 32'hFFFF_FFFF; pending_cmds.push_back(c);
    c.dip = 32'h7000_0000; pending_cmds.push_back(c); // miss
    c = blank_cmd(OP_CLEAR); c.hold = 1; pending_cmds.push_back(c);

    // fill both tables to no-space, probe, then random traffic
    for (int i = 0; i < 70; i++) begin
      c = good_action(blank_cmd(OP_ADD_FLOW)); c.proto = PROTO_TCP;
      pending_cmds.push_back(c);
      c = good_action(blank_cmd(OP_ADD_ROUTE)); c.depth = 6'd32;
      pending_cmds.push_back(c);
    end
    c = blank_cmd(OP_LOOKUP); pending_cmds.push_back(c);
    c = blank_cmd(OP_CLEAR); c.hold = 1; pending_cmds.push_back(c);
    for (int i = 0; i < 385; i++) begin
      c = rand_cmd();
      if (i == 200) c.hold = 1;
      pending_cmds.push_back(c);
    end
  end

  // Driver: inputs change on the falling edge.
  always @(negedge clk) begin
    cmd_t c;
    if (rst_n && (!start || took)) begin
      // previous beat was taken at the last rising edge (or nothing pending)
      if (pending_cmds.size() == 0) begin
        start <= 1'b0;
        stim_done = 1;
      end else if (pending_cmds[0].hold && expected_verdicts.size() != 0) begin
        start <= 1'b0;
      end else if (!gap_free && $urandom_range(0, 99) < 36) begin
        start <= 1'b0;
      end else begin
        c = pending_cmds.pop_front();
        start <= 1'b1;
        in_action <= c.op;
        in_src_ip <= c.sip;
        in_dst_ip <= c.dip;
        in_l4_sport <= c.sport;
        in_l4_dport <= c.dport;
        in_proto <= c.proto;
        in_prefix_depth <= c.depth;
        in_act_type <= c.atype;
        in_rewrite_mask <= c.amask;
        in_reserved_nonzero <= c.resv;
        sent++;
        gap_free = (sent > 300 && sent < 380);
      end
    end
  end

  // Monitor: sample at the rising edge; predict on acceptance.
  always @(posedge clk) begin
    cmd_t c;
    verdict_t v, e;
    bit moved;
    moved = 0;
    took = rst_n && start && !busy;
    if (rst_n) begin
      if (took) begin
        c = '{in_action, in_src_ip, in_dst_ip, in_l4_sport, in_l4_dport, in_proto,
              in_prefix_depth, in_act_type, in_rewrite_mask, in_reserved_nonzero, 1'b0};
        expected_verdicts.push_back(classify(c));
        moved = 1;
      end
      if (out_valid) begin
        moved = 1;
        v = '{out_status, out_hit_type, out_hit_mask, out_rule_slot};
        if (expected_verdicts.size() == 0) begin
          $error("result beat with nothing expected: status %0d", v.status);
          errors++;
        end else begin
          e = expected_verdicts.pop_front();
          if (v.status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, v.status); errors++;
          end
          if (v.htype !== e.htype) begin
            $error("hit_type: expected %0d actual %0d", e.htype, v.htype); errors++;
          end
          if (v.hmask !== e.hmask) begin
            $error("hit_mask: expected %0d actual %0d", e.hmask, v.hmask); errors++;
          end
          if (v.idx !== e.idx) begin
            $error("rule_slot: expected %0d actual %0d", e.idx, v.idx); errors++;
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  // Reset, then wait for drain; the watchdog covers a hang.
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (!(stim_done && expected_verdicts.size() == 0 && !start) &&
           quiet_cycles < WATCHDOG_LIMIT)
      @(posedge clk);
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
    end else begin
      repeat (300) @(posedge clk);   // tail: any stray strobe would be flagged
      if (errors == 0 && expected_verdicts.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
    end
    $finish;
  end

endmodule
